/* src/assert_macros.svh */
// Assertion macros shared by the expander RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// a never holds
`define ASSERT_NEVER(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("assertion failed");

`endif

/* src/pie_pkg.sv */
// Package: types and constants of the packed indexed pixel expander
`timescale 1ns / 1ps
package pie_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int MAX_DIMENSION_DEF = 4096;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  localparam int CFG_DW  = 13;
  localparam int CFG_IW  = 3;

  localparam logic [CFG_IW-1:0] REG_PIXEL_SIZE   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MONO_MODE    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MASK_ENABLE  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 3'd4;

  localparam logic [23:0] WHITE_RGB   = 24'hffffff;
  localparam logic [23:0] MAGENTA_RGB = 24'hff00ff;
  localparam logic [23:0] BLACK_RGB   = 24'h000000;

  typedef struct packed {
    logic [1:0]  pixel_size_code;
    logic        mono_mode;
    logic        mask_enable;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  // One queued request, already classified
  typedef struct packed {
    logic        is_pal;
    logic [7:0]  data;
    logic [7:0]  mask;
    logic [7:0]  idx;
    logic [23:0] rgb;
  } item_t;

endpackage

/* src/pie_ifs.sv */
// Interfaces: input request channel and output pixel channel
`timescale 1ns / 1ps
interface pie_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic [7:0]  mask_byte;
  logic [7:0]  palette_index;
  logic [15:0] red_component;
  logic [15:0] green_component;
  logic [15:0] blue_component;

  modport source (
    output valid, cmd, data_byte, mask_byte, palette_index,
           red_component, green_component, blue_component,
    input  ready
  );
  modport sink (
    input  valid, cmd, data_byte, mask_byte, palette_index,
           red_component, green_component, blue_component,
    output ready
  );
endinterface

interface pie_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_rgb;
  logic        row_end;
  logic        image_end;
  logic        last;

  modport source (output valid, pixel_rgb, row_end, image_end, last, input ready);
  modport sink (input valid, pixel_rgb, row_end, image_end, last, output ready);
endinterface

/* src/pie_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end
`timescale 1ns / 1ps
module pie_front
  import pie_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  pie_in_if.sink       pix_in,
  output logic         head_valid,
  output item_t        head,
  input  logic         pop
);

  item_t           queue [QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    count;
  logic            push;
  item_t           entry;

  assign pix_in.ready = (count != (QAW+1)'(QUEUE_DEPTH));
  assign push         = pix_in.valid && pix_in.ready;
  assign head_valid   = (count != '0);
  assign head         = queue[rd_ptr];

  always_comb begin
    entry.is_pal = pix_in.cmd;
    entry.data   = pix_in.data_byte;
    entry.mask   = pix_in.mask_byte;
    entry.idx    = pix_in.palette_index;
    entry.rgb    = {pix_in.red_component[15:8], pix_in.green_component[15:8],
                    pix_in.blue_component[15:8]};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

endmodule

/* src/pie_back.sv */
// Back end: palette store, byte-to-pixel expansion, raster counters, output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pie_back
  import pie_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         head_valid,
  input  item_t        head,
  output logic         pop,
  pie_out_if.source    pix_out
);

  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW  = $clog2(MAX_DIMENSION);
  localparam int EW  = (CW + 1 > CFG_DW) ? CW + 1 : CFG_DW;

  logic [23:0]    pal_mem [PALETTE_DEPTH];
  logic [23:0]    rd_q;

  logic [CW-1:0]  col_cnt;
  logic [CW-1:0]  row_cnt;
  logic [2:0]     slice;

  logic           b_valid;
  logic           b_use_pal;
  logic           b_black;
  logic [23:0]    b_rgb;
  logic           b_row_end;
  logic           b_img_end;
  logic           b_last;

  logic [EW-1:0]  eff_w;
  logic [EW-1:0]  eff_h;
  logic [1:0]     lg;
  logic [2:0]     last_slice;
  logic [2:0]     shift;
  logic [7:0]     pmask;
  logic [7:0]     code;
  logic           mask_bit;
  logic [23:0]    mono_rgb;
  logic           col_hit;
  logic           row_hit;
  logic           is_data;
  logic           pal_wr;
  logic           b_open;
  logic           a_adv;
  logic           a_last;
  logic           code_ok;
  logic           idx_ok;

  always_comb begin
    if (cfg.image_width == '0) begin
      eff_w = EW'(1);
    end else if (EW'(cfg.image_width) > EW'(MAX_DIMENSION)) begin
      eff_w = EW'(MAX_DIMENSION);
    end else begin
      eff_w = EW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      eff_h = EW'(1);
    end else if (EW'(cfg.image_height) > EW'(MAX_DIMENSION)) begin
      eff_h = EW'(MAX_DIMENSION);
    end else begin
      eff_h = EW'(cfg.image_height);
    end
  end

  // log2 of bits per pixel
  assign lg = cfg.mono_mode ? 2'd0 : cfg.pixel_size_code;

  always_comb begin
    case (lg)
      2'd0: begin
        last_slice = 3'd7;
        shift      = 3'd7 - slice;
        pmask      = 8'h01;
      end
      2'd1: begin
        last_slice = 3'd3;
        shift      = 3'd6 - {slice[1:0], 1'b0};
        pmask      = 8'h03;
      end
      2'd2: begin
        last_slice = 3'd1;
        shift      = 3'd4 - {slice[0], 2'b00};
        pmask      = 8'h0f;
      end
      default: begin
        last_slice = 3'd0;
        shift      = 3'd0;
        pmask      = 8'hff;
      end
    endcase
  end

  assign code     = (head.data >> shift) & pmask;
  assign mask_bit = head.mask[shift];

  always_comb begin
    mono_rgb = code[0] ? BLACK_RGB : WHITE_RGB;
    if (cfg.mask_enable && !mask_bit) begin
      mono_rgb = MAGENTA_RGB;
    end
  end

  assign col_hit = (EW'(col_cnt) + EW'(1)) >= eff_w;
  assign row_hit = (EW'(row_cnt) + EW'(1)) >= eff_h;
  assign code_ok = {1'b0, code} < 9'(PALETTE_DEPTH);
  assign idx_ok  = {1'b0, head.idx} < 9'(PALETTE_DEPTH);

  assign is_data = head_valid && !head.is_pal;
  assign pal_wr  = head_valid && head.is_pal;
  assign b_open  = !b_valid || pix_out.ready;
  assign a_adv   = is_data && b_open;
  assign a_last  = col_hit || (slice == last_slice);
  assign pop     = pal_wr || (a_adv && a_last);

  always_ff @(posedge clk) begin
    if (pal_wr && idx_ok) begin
      pal_mem[head.idx[PAW-1:0]] <= head.rgb;
    end
    if (a_adv) begin
      rd_q <= pal_mem[code[PAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_use_pal <= !cfg.mono_mode;
      b_black   <= !code_ok;
      b_rgb     <= mono_rgb;
      b_row_end <= col_hit;
      b_img_end <= col_hit && row_hit;
      b_last    <= a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      slice   <= '0;
      col_cnt <= '0;
      row_cnt <= '0;
    end else begin
      if (b_open) begin
        b_valid <= a_adv;
      end
      if (a_adv) begin
        slice <= a_last ? 3'd0 : slice + 3'd1;
        if (col_hit) begin
          col_cnt <= '0;
          row_cnt <= row_hit ? '0 : row_cnt + CW'(1);
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
    end
  end

  assign pix_out.valid     = b_valid;
  assign pix_out.pixel_rgb = b_use_pal ? (b_black ? BLACK_RGB : rd_q) : b_rgb;
  assign pix_out.row_end   = b_row_end;
  assign pix_out.image_end = b_img_end;
  assign pix_out.last      = b_last;

  `ASSERT_NEVER(a_slice_range, clk, rst, is_data && (slice > last_slice))
  `ASSERT_NEXT(a_image_wrap, clk, rst, a_adv && col_hit && row_hit, (row_cnt == '0) && (col_cnt == '0))
  `ASSERT_IMPLIES(a_end_flags, clk, rst, b_valid && b_img_end, b_row_end && b_last)

endmodule

/* src/packed_indexed_pixel_expander_core.sv */
// Top level: configuration registers, front end queue and expansion back end
`timescale 1ns / 1ps
// A data byte is written into the queue; its first pixel is then registered at the output.
// Throughput: one pixel per cycle unless the output stalls; a byte gives 8 / bits-per-pixel
// pixels (8 in mono), fewer when a row ends inside it; a palette write gives no pixel.
// A four-entry queue lets requests be taken while the output is stalled.
// Reset clears counters, queue and output; registers take their defaults; palette undefined.
module packed_indexed_pixel_expander_core
  import pie_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic              clk,
  input  logic              rst,
  pie_in_if.sink            pix_in,
  pie_out_if.source         pix_out,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t  cfg;
  logic  head_valid;
  item_t head;
  logic  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_size_code <= 2'd3;
      cfg.mono_mode       <= 1'b0;
      cfg.mask_enable     <= 1'b0;
      cfg.image_width     <= 13'd1;
      cfg.image_height    <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_SIZE:   cfg.pixel_size_code <= cfg_data[1:0];
        REG_MONO_MODE:    cfg.mono_mode       <= cfg_data[0];
        REG_MASK_ENABLE:  cfg.mask_enable     <= cfg_data[0];
        REG_IMAGE_WIDTH:  cfg.image_width     <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: cfg.image_height    <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  pie_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  pie_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .pix_out    (pix_out)
  );

endmodule

/* bench/testbench.sv */
// Testbench: directed table and random phases, pixels checked against an own predictor
`timescale 1ns / 1ps
module testbench;
  import pie_pkg::*;

  localparam int unsigned LIMIT         = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASES        = 4;
  localparam int unsigned PHASE_ITEMS   = 20;

  typedef struct packed {
    logic [23:0] rgb;
    logic        row_end;
    logic        image_end;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data;
    logic [7:0]  mask;
    logic [7:0]  idx;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } request_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PAL, ROW_DATA} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CFG_IW-1:0] reg_idx;
    logic [CFG_DW-1:0] reg_val;
    request_t          rq;
    logic              typed;
    pixel_t            want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  pie_in_if  pix_in ();
  pie_out_if pix_out ();

  packed_indexed_pixel_expander_core u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .pix_out   (pix_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [23:0]  palette [256];
  bit           palette_set [256];
  logic [1:0]   size_code = 2'd3;
  logic         mono = 1'b0;
  logic         mask_on = 1'b0;
  logic [12:0]  width_reg = 13'd1;
  logic [12:0]  height_reg = 13'd1;
  int unsigned  column = 0;
  int unsigned  row = 0;

  pixel_t       expected_pixels [$];
  pixel_t       head_pixel;
  stim_row_t    plan [$];
  request_t     rq;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  send_gap [3] = '{30, 76, 0};
  int unsigned  recv_gap [3] = '{76, 30, 0};
  bit           quiet = 1'b1;
  int unsigned  errors = 0;
  int unsigned  requests_sent = 0;
  int unsigned  palette_writes = 0;
  int unsigned  reg_writes = 0;
  int unsigned  pixels_checked = 0;
  int unsigned  cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned eff_dim(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
    return 32'(v);
  endfunction

  // Expands one data byte into pending pixels; returns how many
  function automatic int expand_byte(input logic [7:0] data, input logic [7:0] mask);
    int unsigned wd, ht, bpp, shift;
    logic [7:0]  code;
    pixel_t      px;
    int          n;
    wd = eff_dim(width_reg);
    ht = eff_dim(height_reg);
    bpp = mono ? 1 : (1 << size_code);
    n = 0;
    for (int k = 0; k < 8 / bpp; k++) begin
      shift = 8 - bpp * (k + 1);
      code = 8'((data >> shift) & ((1 << bpp) - 1));
      if (mono) begin
        px.rgb = (code != 0) ? BLACK_RGB : WHITE_RGB;
        if (mask_on && !mask[shift]) px.rgb = MAGENTA_RGB;
      end else begin
        px.rgb = palette[code];
      end
      px.row_end = 1'b0;
      px.image_end = 1'b0;
      if (column + 1 >= wd) begin
        px.row_end = 1'b1;
        column = 0;
        if (row + 1 >= ht) begin
          px.image_end = 1'b1;
          row = 0;
        end else begin
          row++;
        end
      end else begin
        column++;
      end
      px.last = px.row_end || (k == 8 / bpp - 1);
      expected_pixels.push_back(px);
      n++;
      if (px.row_end) break;
    end
    return n;
  endfunction

  // In colour mode, steer every code of the byte onto a loaded palette entry
  function automatic logic [7:0] legal_byte(input logic [7:0] raw);
    logic [7:0]  b, field;
    int unsigned bpp, pm, code, tries;
    b = raw;
    if (mono) return b;
    bpp = 1 << size_code;
    pm = (1 << bpp) - 1;
    for (int sh = 0; sh < 8; sh += bpp) begin
      code = (b >> sh) & pm;
      tries = 0;
      while (!palette_set[code] && tries < 8) begin
        code = $urandom_range(pm);
        tries++;
      end
      if (!palette_set[code]) code = 0;
      field = 8'(pm << sh);
      b = (b & ~field) | 8'(code << sh);
    end
    return b;
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 12) return 8191;
    if (r < 16) return 4096;
    if (r < 19) return $urandom_range(8190, 4097);
    if (r < 27) return 1;
    return $urandom_range(12, 2);
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IW-1:0] idx,
                                        input logic [CFG_DW-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t pal_row(input logic [7:0] idx, input logic [15:0] red,
                                        input logic [15:0] green, input logic [15:0] blue);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PAL;
    r.rq = '{1'b1, 8'h00, 8'h00, idx, red, green, blue};
    return r;
  endfunction

  function automatic stim_row_t dat_row(input logic [7:0] data, input logic [7:0] mask);
    stim_row_t r;
    r = '0;
    r.kind = ROW_DATA;
    r.rq = '{1'b0, data, mask, 8'h00, 16'h0000, 16'h0000, 16'h0000};
    return r;
  endfunction

  function automatic stim_row_t chk_row(input logic [7:0] data, input logic [7:0] mask,
                                        input logic [23:0] rgb, input logic re,
                                        input logic ie);
    stim_row_t r;
    r = dat_row(data, mask);
    r.typed = 1'b1;
    r.want = '{rgb, re, ie, 1'b1};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch at pixel %0d: %s got %0h expected %0h",
             pixels_checked, what, got, want);
    errors++;
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PIXEL_SIZE:   size_code = val[1:0];
      REG_MONO_MODE:    mono = val[0];
      REG_MASK_ENABLE:  mask_on = val[0];
      REG_IMAGE_WIDTH:  width_reg = val;
      REG_IMAGE_HEIGHT: height_reg = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // Hold the sender until every pending pixel is out and the queue has emptied
  task automatic wait_quiet();
    pix_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    quiet = 1'b1;
  endtask

  task automatic send_request(input request_t r, input logic typed, input pixel_t want);
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.cmd <= r.cmd;
    pix_in.data_byte <= r.data;
    pix_in.mask_byte <= r.mask;
    pix_in.palette_index <= r.idx;
    pix_in.red_component <= r.red;
    pix_in.green_component <= r.green;
    pix_in.blue_component <= r.blue;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    quiet = 1'b0;
    requests_sent++;
    if (r.cmd) begin
      palette[r.idx] = {r.red[15:8], r.green[15:8], r.blue[15:8]};
      palette_set[r.idx] = 1'b1;
      palette_writes++;
    end else begin
      n = expand_byte(r.data, r.mask);
      if (typed) begin
        repeat (n) void'(expected_pixels.pop_back());
        expected_pixels.push_back(want);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (pix_out.valid && pix_out.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel with none pending", pix_out.pixel_rgb, '0);
        end else begin
          head_pixel = expected_pixels.pop_front();
          if (pix_out.pixel_rgb !== head_pixel.rgb)
            report_mismatch("pixel_rgb", pix_out.pixel_rgb, head_pixel.rgb);
          if (pix_out.row_end !== head_pixel.row_end)
            report_mismatch("row_end", 24'(pix_out.row_end), 24'(head_pixel.row_end));
          if (pix_out.image_end !== head_pixel.image_end)
            report_mismatch("image_end", 24'(pix_out.image_end),
                            24'(head_pixel.image_end));
          if (pix_out.last !== head_pixel.last)
            report_mismatch("last", 24'(pix_out.last), 24'(head_pixel.last));
          pixels_checked++;
        end
      end
      pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end else begin
      pix_out.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout with %0d pixels pending", expected_pixels.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_PIXEL_SIZE;
    cfg_data <= '0;
    pix_in.valid <= 1'b0;
    pix_in.cmd <= 1'b0;
    pix_in.data_byte <= '0;
    pix_in.mask_byte <= '0;
    pix_in.palette_index <= '0;
    pix_in.red_component <= '0;
    pix_in.green_component <= '0;
    pix_in.blue_component <= '0;

    // reset config: 8 bpp colour, 1 x 1 image, so each byte gives one flagged pixel
    plan.push_back(pal_row(8'h00, 16'h0000, 16'h0000, 16'h0000));
    plan.push_back(pal_row(8'hff, 16'hffff, 16'hffff, 16'hffff));
    plan.push_back(pal_row(8'h80, 16'h1234, 16'habcd, 16'h00ff));
    plan.push_back(pal_row(8'h01, 16'hff00, 16'h00ff, 16'h8000));
    plan.push_back(pal_row(8'h02, 16'h5a5a, 16'ha5a5, 16'h7fff));
    plan.push_back(pal_row(8'h03, 16'h00ff, 16'hff00, 16'h0100));
    plan.push_back(chk_row(8'h00, 8'h00, 24'h000000, 1'b1, 1'b1));
    plan.push_back(chk_row(8'hff, 8'hff, 24'hffffff, 1'b1, 1'b1));
    plan.push_back(chk_row(8'h80, 8'h00, 24'h12ab00, 1'b1, 1'b1));
    plan.push_back(chk_row(8'h01, 8'hff, 24'hff0080, 1'b1, 1'b1));
    // oversized width, zero height, 2 bpp
    plan.push_back(cfg_row(REG_IMAGE_WIDTH, 13'd8191));
    plan.push_back(cfg_row(REG_IMAGE_HEIGHT, 13'd0));
    plan.push_back(cfg_row(REG_PIXEL_SIZE, 13'd1));
    plan.push_back(dat_row(8'h1b, 8'h00));
    plan.push_back(dat_row(8'he4, 8'hff));
    // width shrunk mid-row
    plan.push_back(cfg_row(REG_IMAGE_WIDTH, 13'd2));
    plan.push_back(dat_row(8'h55, 8'h00));
    // 1 bpp, rows of 5 leave bits over
    plan.push_back(cfg_row(REG_PIXEL_SIZE, 13'd0));
    plan.push_back(cfg_row(REG_IMAGE_WIDTH, 13'd5));
    plan.push_back(cfg_row(REG_IMAGE_HEIGHT, 13'd2));
    plan.push_back(dat_row(8'ha5, 8'h00));
    plan.push_back(dat_row(8'h3c, 8'h00));
    plan.push_back(dat_row(8'h0f, 8'h00));
    plan.push_back(cfg_row(REG_PIXEL_SIZE, 13'd2));
    plan.push_back(dat_row(8'h12, 8'h00));
    plan.push_back(dat_row(8'h30, 8'h00));
    // mono, mask off then on
    plan.push_back(cfg_row(REG_MONO_MODE, 13'd1));
    plan.push_back(cfg_row(REG_IMAGE_WIDTH, 13'd8));
    plan.push_back(cfg_row(REG_IMAGE_HEIGHT, 13'd8191));
    plan.push_back(dat_row(8'ha5, 8'h00));
    plan.push_back(cfg_row(REG_MASK_ENABLE, 13'd1));
    plan.push_back(dat_row(8'h0f, 8'hf0));
    plan.push_back(dat_row(8'hff, 8'h7e));
    plan.push_back(cfg_row(REG_IMAGE_WIDTH, 13'd0));
    plan.push_back(cfg_row(REG_IMAGE_HEIGHT, 13'd1));
    plan.push_back(chk_row(8'h00, 8'h00, MAGENTA_RGB, 1'b1, 1'b1));
    plan.push_back(chk_row(8'h7f, 8'h80, WHITE_RGB, 1'b1, 1'b1));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = send_gap[0];
    recv_idle_pct = recv_gap[0];
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!quiet) wait_quiet();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_request(plan[i].rq, plan[i].typed, plan[i].want);
      end
    end

    for (int seg = 0; seg < 3; seg++) begin
      send_idle_pct = send_gap[seg];
      recv_idle_pct = recv_gap[seg];
      for (int ph = 0; ph < PHASES; ph++) begin
        if (!quiet) wait_quiet();
        write_reg(REG_PIXEL_SIZE, CFG_DW'($urandom_range(3)));
        write_reg(REG_MONO_MODE, CFG_DW'($urandom_range(1)));
        write_reg(REG_MASK_ENABLE, CFG_DW'($urandom_range(1)));
        write_reg(REG_IMAGE_WIDTH, CFG_DW'(pick_dim()));
        write_reg(REG_IMAGE_HEIGHT, CFG_DW'(pick_dim()));
        repeat (PHASE_ITEMS) begin
          rq.mask = 8'($urandom_range(255));
          rq.idx = 8'($urandom_range(255));
          rq.red = 16'($urandom_range(65535));
          rq.green = 16'($urandom_range(65535));
          rq.blue = 16'($urandom_range(65535));
          rq.cmd = ($urandom_range(99) < (mono ? 10 : 25));
          rq.data = rq.cmd ? 8'($urandom_range(255)) : legal_byte(8'($urandom_range(255)));
          send_request(rq, 1'b0, '0);
        end
      end
    end

    wait_quiet();
    $display("ran %0d requests (%0d palette loads) over %0d register writes",
             requests_sent, palette_writes, reg_writes);
    $display("checked %0d pixels across mono, masked and 1/2/4/8 bpp colour, %0d mismatches",
             pixels_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
